// ===== rtl/core/cfdla_pkg.sv =====
`default_nettype none
package cfdla_pkg;

	localparam int MAX_LUT_WIDTH = 64;
	localparam int MIN_LUT_WIDTH = 3;

	localparam int DIR_W    = 16;
	localparam int WIDTH_W  = 7;
	localparam int BETA_W   = 24;
	localparam int GAIN_W   = 16;
	localparam int OFS_W    = 25;
	localparam int FACE_W   = 3;
	localparam int GRID_W   = $clog2(MAX_LUT_WIDTH);
	localparam int HALF_W   = $clog2(MAX_LUT_WIDTH);
	localparam int LIN_W    = GRID_W + GRID_W;
	localparam int ENTRY_W  = 17;

	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;

	// register indexes
	localparam logic [1:0] REG_LUT_WIDTH   = 2'd0;
	localparam logic [1:0] REG_WARP_BETA   = 2'd1;
	localparam logic [1:0] REG_WARP_GAIN   = 2'd2;
	localparam logic [1:0] REG_WARP_OFFSET = 2'd3;

	localparam logic [WIDTH_W-1:0] RST_LUT_WIDTH   = 7'd64;
	localparam logic [BETA_W-1:0]  RST_WARP_BETA   = 24'd65536;
	localparam logic [GAIN_W-1:0]  RST_WARP_GAIN   = 16'd27146;
	localparam logic [OFS_W-1:0]   RST_WARP_OFFSET = 25'h1FD95F7;

	// face codes
	localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd0;
	localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd1;
	localparam logic [FACE_W-1:0] FACE_POS_X = 3'd2;
	localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd3;
	localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd4;
	localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd5;

	// 0.5 in Q2.14, 1.0 and 0.5 in Q.16
	localparam logic signed [DIR_W-1:0] HALF_Q14 = 16'sd8192;
	localparam int ONE_Q16  = 65536;
	localparam int HALF_Q16 = 32768;

endpackage
`default_nettype wire

// ===== rtl/core/cube_face_direction_lut_address_top.sv =====
// channel | handshake               | payload
// --------+-------------------------+----------------------------------------
// in      | in_valid / in_ready     | dir_x, dir_y, dir_z
// out     | out_valid / out_ready   | face, grid_u, grid_v, entry_offset
// cfg     | psel/penable/pwrite     | paddr, pwdata, prdata (pready tied high)
//
// Eight register stages, one item per cycle sustained while out_ready is high.
// The stage depth is set by the 26x17 gain multiply and the 26x26 square.
// Each stage holds when it is full and the stage after it cannot take its item,
// so bubbles close up during an output stall and nothing is dropped.
// arst_n clears the stage valids and loads the register reset values.
`default_nettype none
module cube_face_direction_lut_address_top (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   psel,
	input  wire logic                                   penable,
	input  wire logic                                   pwrite,
	input  wire logic [cfdla_pkg::ADDR_W-1:0]           paddr,
	input  wire logic [cfdla_pkg::DATA_W-1:0]           pwdata,
	output logic      [cfdla_pkg::DATA_W-1:0]           prdata,
	output logic                                        pready,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic signed [cfdla_pkg::DIR_W-1:0]     dir_x,
	input  wire logic signed [cfdla_pkg::DIR_W-1:0]     dir_y,
	input  wire logic signed [cfdla_pkg::DIR_W-1:0]     dir_z,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic [cfdla_pkg::FACE_W-1:0]                face,
	output logic [cfdla_pkg::GRID_W-1:0]                grid_u,
	output logic [cfdla_pkg::GRID_W-1:0]                grid_v,
	output logic [cfdla_pkg::ENTRY_W-1:0]               entry_offset
);

	localparam int NSTG = 8;

	// config registers
	logic [cfdla_pkg::WIDTH_W-1:0] lut_width_q;
	logic [cfdla_pkg::BETA_W-1:0]  warp_beta_q;
	logic [cfdla_pkg::GAIN_W-1:0]  warp_gain_q;
	logic [cfdla_pkg::OFS_W-1:0]   warp_offset_q;
	logic                          cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lut_width_q   <= cfdla_pkg::RST_LUT_WIDTH;
			warp_beta_q   <= cfdla_pkg::RST_WARP_BETA;
			warp_gain_q   <= cfdla_pkg::RST_WARP_GAIN;
			warp_offset_q <= cfdla_pkg::RST_WARP_OFFSET;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				cfdla_pkg::REG_LUT_WIDTH:   lut_width_q   <= pwdata[cfdla_pkg::WIDTH_W-1:0];
				cfdla_pkg::REG_WARP_BETA:   warp_beta_q   <= pwdata[cfdla_pkg::BETA_W-1:0];
				cfdla_pkg::REG_WARP_GAIN:   warp_gain_q   <= pwdata[cfdla_pkg::GAIN_W-1:0];
				cfdla_pkg::REG_WARP_OFFSET: warp_offset_q <= pwdata[cfdla_pkg::OFS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			cfdla_pkg::REG_LUT_WIDTH:
				prdata = {{(cfdla_pkg::DATA_W-cfdla_pkg::WIDTH_W){1'b0}}, lut_width_q};
			cfdla_pkg::REG_WARP_BETA:
				prdata = {{(cfdla_pkg::DATA_W-cfdla_pkg::BETA_W){1'b0}}, warp_beta_q};
			cfdla_pkg::REG_WARP_GAIN:
				prdata = {{(cfdla_pkg::DATA_W-cfdla_pkg::GAIN_W){1'b0}}, warp_gain_q};
			cfdla_pkg::REG_WARP_OFFSET:
				prdata = {{(cfdla_pkg::DATA_W-cfdla_pkg::OFS_W){warp_offset_q[cfdla_pkg::OFS_W-1]}},
					warp_offset_q};
			default: prdata = '0;
		endcase
	end

	// effective width and half span
	logic [cfdla_pkg::WIDTH_W-1:0] w_eff;
	logic [cfdla_pkg::WIDTH_W-1:0] w_max;
	logic [cfdla_pkg::HALF_W-1:0]  half_span;

	always_comb begin
		if (lut_width_q < cfdla_pkg::WIDTH_W'(cfdla_pkg::MIN_LUT_WIDTH))
			w_eff = cfdla_pkg::WIDTH_W'(cfdla_pkg::MIN_LUT_WIDTH);
		else if (lut_width_q > cfdla_pkg::WIDTH_W'(cfdla_pkg::MAX_LUT_WIDTH))
			w_eff = cfdla_pkg::WIDTH_W'(cfdla_pkg::MAX_LUT_WIDTH);
		else
			w_eff = lut_width_q;
	end
	assign w_max     = w_eff - 1'b1;
	assign half_span = w_max[cfdla_pkg::HALF_W:1];

	// stage valids and per-stage enables
	logic [NSTG:1]   vld_q;
	logic [NSTG+1:1] en;

	always_comb begin
		en[NSTG+1] = out_ready;
		for (int k = NSTG; k >= 1; k--)
			en[k] = !vld_q[k] || en[k+1];
	end

	assign in_ready  = en[1];
	assign out_valid = vld_q[NSTG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1])
				vld_q[1] <= in_valid;
			for (int k = 2; k <= NSTG; k++)
				if (en[k])
					vld_q[k] <= vld_q[k-1];
		end
	end

	// s1: face select, magnitude, offset subtract
	logic [cfdla_pkg::FACE_W-1:0]  face_c;
	logic signed [cfdla_pkg::DIR_W-1:0] fsel_c [2];
	logic signed [cfdla_pkg::DIR_W:0]   fext_c [2];
	logic [cfdla_pkg::DIR_W:0]     fabs_c [2];
	logic [cfdla_pkg::DIR_W+2:0]   mag_c [2];

	always_comb begin
		if (dir_z > cfdla_pkg::HALF_Q14) begin
			face_c = cfdla_pkg::FACE_POS_Z; fsel_c[0] = dir_x; fsel_c[1] = dir_y;
		end else if (dir_z < -cfdla_pkg::HALF_Q14) begin
			face_c = cfdla_pkg::FACE_NEG_Z; fsel_c[0] = dir_x; fsel_c[1] = dir_y;
		end else if (dir_x > cfdla_pkg::HALF_Q14) begin
			face_c = cfdla_pkg::FACE_POS_X; fsel_c[0] = dir_z; fsel_c[1] = dir_y;
		end else if (dir_x < -cfdla_pkg::HALF_Q14) begin
			face_c = cfdla_pkg::FACE_NEG_X; fsel_c[0] = dir_z; fsel_c[1] = dir_y;
		end else if (dir_y > 16'sd0) begin
			face_c = cfdla_pkg::FACE_POS_Y; fsel_c[0] = dir_x; fsel_c[1] = dir_z;
		end else begin
			face_c = cfdla_pkg::FACE_NEG_Y; fsel_c[0] = dir_x; fsel_c[1] = dir_z;
		end
		for (int l = 0; l < 2; l++) begin
			fext_c[l] = {fsel_c[l][cfdla_pkg::DIR_W-1], fsel_c[l]};
			fabs_c[l] = fext_c[l][cfdla_pkg::DIR_W] ? $unsigned(-fext_c[l]) : $unsigned(fext_c[l]);
			mag_c[l]  = {fabs_c[l], 2'b00};
		end
	end

	logic [cfdla_pkg::FACE_W-1:0] face_s1, face_s2, face_s3, face_s4, face_s5, face_s6, face_s7;
	logic [1:0]          pos_s1, pos_s2, pos_s3;
	logic signed [25:0]  a_s1 [2];
	logic signed [25:0]  x_s2 [2];
	logic [34:0]         x2_s3 [2];
	logic signed [36:0]  wp_s4 [2];
	logic signed [42:0]  t_s5 [2];
	logic [cfdla_pkg::GRID_W-1:0] u_s6, v_s6, u_s7, v_s7;
	logic [cfdla_pkg::LIN_W-1:0]  lin_s7;

	always_ff @(posedge clk) begin
		if (en[1] && in_valid) begin
			face_s1 <= face_c;
			for (int l = 0; l < 2; l++) begin
				pos_s1[l] <= (fsel_c[l] > 16'sd0);
				a_s1[l]   <= $signed({7'b0, mag_c[l]})
					- $signed({warp_offset_q[cfdla_pkg::OFS_W-1], warp_offset_q});
			end
		end
	end

	// s2: gain multiply, floor to Q.16
	logic signed [42:0] prod_c [2];
	always_comb begin
		for (int l = 0; l < 2; l++)
			prod_c[l] = a_s1[l] * $signed({1'b0, warp_gain_q});
	end

	always_ff @(posedge clk) begin
		if (en[2] && vld_q[1]) begin
			face_s2 <= face_s1;
			pos_s2  <= pos_s1;
			for (int l = 0; l < 2; l++)
				x_s2[l] <= prod_c[l][41:16];
		end
	end

	// s3: square, floor to Q.16
	logic signed [51:0] sq_c [2];
	always_comb begin
		for (int l = 0; l < 2; l++)
			sq_c[l] = x_s2[l] * x_s2[l];
	end

	always_ff @(posedge clk) begin
		if (en[3] && vld_q[2]) begin
			face_s3 <= face_s2;
			pos_s3  <= pos_s2;
			for (int l = 0; l < 2; l++)
				x2_s3[l] <= sq_c[l][50:16];
		end
	end

	// s4: signed warp plus one
	logic signed [35:0] d_c [2];
	logic signed [35:0] wv_c [2];
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			d_c[l]  = $signed({1'b0, x2_s3[l]}) - $signed({12'b0, warp_beta_q});
			wv_c[l] = pos_s3[l] ? d_c[l] : -d_c[l];
		end
	end

	always_ff @(posedge clk) begin
		if (en[4] && vld_q[3]) begin
			face_s4 <= face_s3;
			for (int l = 0; l < 2; l++)
				wp_s4[l] <= {wv_c[l][35], wv_c[l]} + 37'(cfdla_pkg::ONE_Q16);
		end
	end

	// s5: scale by half span, minus 0.5
	logic signed [42:0] ts_c [2];
	always_comb begin
		for (int l = 0; l < 2; l++)
			ts_c[l] = wp_s4[l] * $signed({1'b0, half_span});
	end

	always_ff @(posedge clk) begin
		if (en[5] && vld_q[4]) begin
			face_s5 <= face_s4;
			for (int l = 0; l < 2; l++)
				t_s5[l] <= ts_c[l] - 43'(cfdla_pkg::HALF_Q16);
		end
	end

	// s6: floor and clamp
	logic signed [26:0] idx_c [2];
	logic [cfdla_pkg::GRID_W-1:0] cl_c [2];
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			idx_c[l] = t_s5[l][42:16];
			if (idx_c[l] < 27'sd0)
				cl_c[l] = '0;
			else if (idx_c[l] > $signed({20'b0, w_max}))
				cl_c[l] = w_max[cfdla_pkg::GRID_W-1:0];
			else
				cl_c[l] = idx_c[l][cfdla_pkg::GRID_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[6] && vld_q[5]) begin
			face_s6 <= face_s5;
			u_s6    <= cl_c[0];
			v_s6    <= cl_c[1];
		end
	end

	// s7: linear grid index
	logic [cfdla_pkg::LIN_W:0] vw_c;
	assign vw_c = v_s6 * w_eff;

	always_ff @(posedge clk) begin
		if (en[7] && vld_q[6]) begin
			face_s7 <= face_s6;
			u_s7    <= u_s6;
			v_s7    <= v_s6;
			lin_s7  <= cfdla_pkg::LIN_W'(vw_c) + cfdla_pkg::LIN_W'(u_s6);
		end
	end

	// s8: entry offset
	logic [cfdla_pkg::ENTRY_W-1:0] six_c, sum_c;
	assign six_c = cfdla_pkg::ENTRY_W'({lin_s7, 2'b00}) + cfdla_pkg::ENTRY_W'({lin_s7, 1'b0});
	assign sum_c = six_c + cfdla_pkg::ENTRY_W'(face_s7);

	always_ff @(posedge clk) begin
		if (en[8] && vld_q[7]) begin
			face         <= face_s7;
			grid_u       <= u_s7;
			grid_v       <= v_s7;
			entry_offset <= {sum_c[cfdla_pkg::ENTRY_W-2:0], 1'b0} + sum_c;
		end
	end

`ifndef SYNTHESIS
	a_face_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> face <= cfdla_pkg::FACE_NEG_Y)
		else $error("face code out of range");

	a_grid_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, grid_u} <= w_max) && ({1'b0, grid_v} <= w_max))
		else $error("grid index beyond clamp");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (&vld_q) && !out_ready)
		else $error("input stalled with a bubble in the pipe");

	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(entry_offset))
		else $error("result changed while stalled");
`endif

endmodule
`default_nettype wire
